FILE: design/kspd_pkg.sv
// Shared types and constants for the key strike percussiveness detector.
// Field widths, register codes and the per-key state word layout live here.
// No dependencies.
`timescale 1ns / 1ps

package kspd_pkg;

  // Fixed field widths.
  localparam int KEY_W  = 6;
  localparam int POS_W  = 16;
  localparam int VEL_W  = 17;
  localparam int FEAT_W = 20;
  localparam int CNT_W  = 16;
  localparam int THR_W  = 17;
  localparam int HOLD_W = 16;

  // Stream word widths, rounded up to whole bytes.
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  // Register bus.
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_VEL_THR = 2'd0;
  localparam logic [1:0] REG_REL_THR = 2'd1;
  localparam logic [1:0] REG_HOLDOFF = 2'd2;

  // Frame counter saturation value.
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // Live configuration.
  typedef struct packed {
    logic [THR_W-1:0]  vel_thr;
    logic [POS_W-1:0]  rel_thr;
    logic [HOLD_W-1:0] holdoff;
  } kspd_cfg_t;

  // Width of one key's state word: last position, stored velocities,
  // feature and frame counter, in that order from the low end.
  function automatic int state_width(input int hist_len);
    return POS_W + VEL_W * (hist_len - 1) + FEAT_W + CNT_W;
  endfunction

endpackage

FILE: design/kspd_cfg_regs.sv
// Configuration registers behind the APB-style port.
// Uses kspd_pkg for the register codes and the configuration struct.
`timescale 1ns / 1ps

module kspd_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kspd_pkg::PADDR_W-1:0] paddr,
  input  logic [kspd_pkg::PDATA_W-1:0] pwdata,
  output logic [kspd_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output kspd_pkg::kspd_cfg_t          cfg
);
  import kspd_pkg::*;

  logic       wr_fire;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_fire = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  // Register writes on the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_fire) begin
      unique case (reg_idx)
        REG_VEL_THR: cfg.vel_thr <= pwdata[THR_W-1:0];
        REG_REL_THR: cfg.rel_thr <= pwdata[POS_W-1:0];
        REG_HOLDOFF: cfg.holdoff <= pwdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back, zero extended.
  always_comb begin
    unique case (reg_idx)
      REG_VEL_THR: prdata = PDATA_W'(cfg.vel_thr);
      REG_REL_THR: prdata = PDATA_W'(cfg.rel_thr);
      REG_HOLDOFF: prdata = PDATA_W'(cfg.holdoff);
      default:     prdata = '0;
    endcase
  end

endmodule

FILE: design/kspd_state_ram.sv
// Per-key state memory: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module kspd_state_ram #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 117
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/kspd_update.sv
// Per-key update: velocity, peak and holdoff tests, window range, feature and
// counter. Combinational read-modify step between state read and write back.
// Uses kspd_pkg for widths and the configuration struct.
`timescale 1ns / 1ps

module kspd_update #(
  parameter int HISTORY_LEN = 5
) (
  input  kspd_pkg::kspd_cfg_t                              cfg,
  input  logic [kspd_pkg::POS_W-1:0]                       position,
  input  logic [kspd_pkg::state_width(HISTORY_LEN)-1:0]    state_in,
  output logic [kspd_pkg::state_width(HISTORY_LEN)-1:0]    state_out,
  output logic [kspd_pkg::FEAT_W-1:0]                      feature
);
  import kspd_pkg::*;

  localparam int HIST_N   = HISTORY_LEN - 1;
  localparam int HIST_LSB = POS_W;
  localparam int FEAT_LSB = HIST_LSB + VEL_W * HIST_N;
  localparam int CNT_LSB  = FEAT_LSB + FEAT_W;

  logic signed [POS_W-1:0] last_pos;
  logic signed [VEL_W-1:0] hist [HIST_N];
  logic [FEAT_W-1:0]       feat;
  logic [CNT_W-1:0]        cnt;

  logic signed [VEL_W-1:0] vel;
  logic signed [VEL_W-1:0] vmin;
  logic signed [VEL_W-1:0] vmax;
  logic [VEL_W:0]          diff;
  logic [VEL_W-1:0]        vrange;
  logic                    strike_test;
  logic                    strike;
  logic                    release_hit;
  logic [FEAT_W-1:0]       feat_strike;
  logic [FEAT_W-1:0]       feat_next;
  logic [CNT_W-1:0]        cnt_base;
  logic [CNT_W-1:0]        cnt_next;

  // Unpack the stored word; the newest stored velocity sits highest.
  always_comb begin
    last_pos = state_in[POS_W-1:0];
    for (int i = 0; i < HIST_N; i++) begin
      hist[i] = state_in[HIST_LSB + i * VEL_W +: VEL_W];
    end
    feat = state_in[FEAT_LSB +: FEAT_W];
    cnt  = state_in[CNT_LSB +: CNT_W];
  end

  // Velocity of this sample.
  assign vel = VEL_W'($signed(position)) - VEL_W'(last_pos);

  // Range of the window: the stored velocities plus the current one.
  always_comb begin
    vmin = vel;
    vmax = vel;
    for (int i = 0; i < HIST_N; i++) begin
      if (hist[i] < vmin) vmin = hist[i];
      if (hist[i] > vmax) vmax = hist[i];
    end
  end

  assign diff   = {vmax[VEL_W-1], vmax} - {vmin[VEL_W-1], vmin};
  assign vrange = diff[VEL_W-1:0];

  // Strike needs an idle feature, the holdoff passed, a velocity peak and a range above vel_thr.
  assign strike_test = (feat == '0) && (cnt > cfg.holdoff) &&
                       (hist[HIST_N-2] <= hist[HIST_N-1]) &&
                       (hist[HIST_N-1] >= vel);
  assign strike      = strike_test && (vrange > cfg.vel_thr);

  // Release once the key comes back above the release level.
  assign release_hit = (feat != '0) &&
                       ($signed(position) > $signed(cfg.rel_thr)) &&
                       (cnt >= cfg.holdoff);

  // Seven times the range, as eight times minus once.
  assign feat_strike = {vrange, 3'b000} - FEAT_W'(vrange);

  always_comb begin
    if (strike) begin
      feat_next = feat_strike;
    end else if (release_hit) begin
      feat_next = '0;
    end else begin
      feat_next = feat;
    end
  end

  // Frame counter restarts on a strike and saturates.
  assign cnt_base = strike ? '0 : cnt;
  assign cnt_next = (cnt_base == COUNT_MAX) ? cnt_base : cnt_base + 1'b1;

  // Pack the new word: history shifts down, current velocity goes on top.
  always_comb begin
    state_out[POS_W-1:0] = position;
    for (int i = 0; i < HIST_N - 1; i++) begin
      state_out[HIST_LSB + i * VEL_W +: VEL_W] = hist[i + 1];
    end
    state_out[HIST_LSB + (HIST_N - 1) * VEL_W +: VEL_W] = vel;
    state_out[FEAT_LSB +: FEAT_W] = feat_next;
    state_out[CNT_LSB +: CNT_W]   = cnt_next;
  end

  assign feature = feat_next;

endmodule

FILE: design/key_strike_percussiveness_detector_core.sv
// Key strike percussiveness detector: per-key state memory with forwarding,
// update logic, register port and output register.
// An accepted input word is registered in the update stage, then its result word in
// the output register, where it waits for m_tready; an output stall holds both.
// Throughput: one word per cycle unless the output stalls; the state read, update and
// write back of a key take one pass through the memory, with the last write forwarded.
// Reset: control and registers clear; per-key valid bits make every key read
// as zero state until first written, so no clearing pass is needed.
// Uses kspd_pkg, kspd_cfg_regs, kspd_state_ram and kspd_update.
`timescale 1ns / 1ps

module key_strike_percussiveness_detector_core #(
  parameter int NUM_KEYS    = 64,
  parameter int HISTORY_LEN = 5
) (
  input  logic                            clk,
  input  logic                            rst,
  // s_tdata: key_index [5:0], position [21:6], zero fill [23:22]
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [kspd_pkg::IN_DATA_W-1:0]  s_tdata,
  // m_tdata: key_out [5:0], feature_value [25:6], zero fill [31:26]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [kspd_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kspd_pkg::PADDR_W-1:0]    paddr,
  input  logic [kspd_pkg::PDATA_W-1:0]    pwdata,
  output logic [kspd_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);
  import kspd_pkg::*;

  localparam int KEY_AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int IDX_W  = (KEY_AW > KEY_W) ? KEY_AW : KEY_W;
  localparam int WORD_W = state_width(HISTORY_LEN);

  kspd_cfg_t cfg;

  logic              in_fire;
  logic              out_free;
  logic [KEY_W-1:0]  in_key;
  logic [KEY_AW-1:0] in_addr;

  logic              s1_valid;
  logic [KEY_W-1:0]  s1_key;
  logic [POS_W-1:0]  s1_pos;
  logic [KEY_AW-1:0] s1_addr;
  logic              s1_in_range;

  logic [WORD_W-1:0] rd_word;
  logic [WORD_W-1:0] old_word;
  logic [WORD_W-1:0] new_word;
  logic [FEAT_W-1:0] new_feat;
  logic              wr_en;

  logic              fwd_valid;
  logic [KEY_AW-1:0] fwd_key;
  logic [WORD_W-1:0] fwd_word;
  logic [NUM_KEYS-1:0] entry_valid;

  logic              out_valid;
  logic [KEY_W-1:0]  out_key;
  logic [FEAT_W-1:0] out_feat;

  // Register port.
  kspd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: the update stage moves whenever the output register is free.
  assign out_free = !out_valid || m_tready;
  assign s_tready = !s1_valid || out_free;
  assign in_fire  = s_tvalid && s_tready;

  assign in_key   = s_tdata[KEY_W-1:0];
  assign in_addr  = KEY_AW'(IDX_W'(in_key));
  assign s1_addr  = KEY_AW'(IDX_W'(s1_key));
  assign s1_in_range = 32'(s1_key) < 32'(NUM_KEYS);

  // State memory, read as a word is accepted.
  kspd_state_ram #(
    .DEPTH  (NUM_KEYS),
    .ADDR_W (KEY_AW),
    .DATA_W (WORD_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (in_addr),
    .rd_data (rd_word),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_data (new_word)
  );

  // Latest write wins over the memory; untouched keys read as zero.
  always_comb begin
    if (fwd_valid && (fwd_key == s1_addr)) begin
      old_word = fwd_word;
    end else if (s1_in_range && entry_valid[s1_addr]) begin
      old_word = rd_word;
    end else begin
      old_word = '0;
    end
  end

  kspd_update #(
    .HISTORY_LEN (HISTORY_LEN)
  ) u_update (
    .cfg       (cfg),
    .position  (s1_pos),
    .state_in  (old_word),
    .state_out (new_word),
    .feature   (new_feat)
  );

  assign wr_en = s1_valid && out_free && s1_in_range;

  // Update stage and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      fwd_valid   <= 1'b0;
      entry_valid <= '0;
    end else begin
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
      if (wr_en) begin
        fwd_valid            <= 1'b1;
        entry_valid[s1_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_key <= in_key;
      s1_pos <= s_tdata[KEY_W +: POS_W];
    end
    if (s1_valid && out_free) begin
      out_key  <= s1_key;
      out_feat <= s1_in_range ? new_feat : '0;
    end
    if (wr_en) begin
      fwd_key  <= s1_addr;
      fwd_word <= new_word;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_W - KEY_W - FEAT_W){1'b0}}, out_feat, out_key};

  // A key outside the table gives a zero feature.
  a_out_of_range_zero: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_free && !s1_in_range) |=> (out_feat == '0))
    else $error("out-of-range key produced a nonzero feature");

  // State is written back only as the update stage hands its word on.
  a_write_on_move: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (out_valid && (out_key == $past(s1_key))))
    else $error("state write without a matching result");

  // A stalled update stage keeps its word.
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_free) |=> (s1_valid && $stable(s1_key) && $stable(s1_pos)))
    else $error("update stage lost its word during a stall");

endmodule

FILE: tb/tb_key_strike_percussiveness_detector_core.sv
// Self-checking testbench for the key strike percussiveness detector core.
// Position words go in on the input stream, and each feature word is checked against a
// per-key predictor. Depends on kspd_pkg and the key_strike_percussiveness_detector_core RTL.
`timescale 1ns / 1ps

module tb_key_strike_percussiveness_detector_core;
  import kspd_pkg::*;

  localparam int KEYS     = 64;
  localparam int HIST     = 5;
  localparam int STORED   = HIST - 1;
  localparam int MAX_SHOW = 40;

  typedef struct {
    logic [KEY_W-1:0]  key;
    logic [FEAT_W-1:0] feat;
  } feature_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // s_tdata: key_index [5:0], position [21:6], zero fill [23:22]
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // m_tdata: key_out [5:0], feature_value [25:6], zero fill [31:26]
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_W-1:0]    paddr = '0;
  logic [PDATA_W-1:0]    pwdata = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  // Predictor copy of the configuration and the per-key state.
  logic [THR_W-1:0]         cfg_vel_thr = '0;
  logic signed [POS_W-1:0]  cfg_rel_thr = '0;
  logic [HOLD_W-1:0]        cfg_holdoff = '0;
  logic signed [POS_W-1:0]  prev_pos   [KEYS];
  logic signed [VEL_W-1:0]  vel_hist   [KEYS][STORED];
  logic [FEAT_W-1:0]        key_feat   [KEYS];
  logic [CNT_W-1:0]         frame_count[KEYS];

  feature_word_t feature_queue[$];
  feature_word_t head;
  int            errors = 0;
  int            words_sent = 0;
  int            words_checked = 0;
  int            active_words = 0;
  int            reg_writes = 0;
  int            ready_hold = 0;
  bit            no_idle = 1'b0;

  key_strike_percussiveness_detector_core #(
    .NUM_KEYS   (KEYS),
    .HISTORY_LEN(HIST)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk = ~clk;

  // Hard stop in case a handshake never completes.
  initial begin
    #5_000_000;
    $display("[key_strike_percussiveness_detector_core] ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (errors < MAX_SHOW) $display("MISMATCH: %s", msg);
    errors++;
  endtask

  function automatic logic signed [POS_W-1:0] clamp_pos(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return POS_W'(v);
  endfunction

  // Advances the predicted state of one key by one sample and returns its feature.
  function automatic logic [FEAT_W-1:0] next_feature(input logic [KEY_W-1:0] k,
                                                     input logic signed [POS_W-1:0] p);
    int               vel, lo, hi, i;
    logic [CNT_W-1:0] f;
    vel = int'(p) - int'(prev_pos[k]);
    f = frame_count[k];
    // A strike needs an idle feature, an expired holdoff and a peak in the previous velocity.
    if (key_feat[k] == '0 && f > cfg_holdoff &&
        vel_hist[k][STORED-2] <= vel_hist[k][STORED-1] &&
        int'(vel_hist[k][STORED-1]) >= vel) begin
      lo = vel;
      hi = vel;
      for (i = 0; i < STORED; i++) begin
        if (int'(vel_hist[k][i]) < lo) lo = int'(vel_hist[k][i]);
        if (int'(vel_hist[k][i]) > hi) hi = int'(vel_hist[k][i]);
      end
      if (hi - lo > int'(cfg_vel_thr)) begin
        key_feat[k] = FEAT_W'(7 * (hi - lo));
        f = '0;
      end
    end else if (key_feat[k] != '0 && p > cfg_rel_thr && f >= cfg_holdoff) begin
      key_feat[k] = '0;
    end
    if (f != COUNT_MAX) f++;
    frame_count[k] = f;
    for (i = 0; i + 1 < STORED; i++) vel_hist[k][i] = vel_hist[k][i+1];
    vel_hist[k][STORED-1] = VEL_W'(vel);
    prev_pos[k] = p;
    return key_feat[k];
  endfunction

  // Sends one position word, with an optional random gap first.
  task automatic send_sample(input logic [KEY_W-1:0] k, input logic signed [POS_W-1:0] p);
    feature_word_t w;
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W - KEY_W - POS_W){1'b0}}, p, k};
    do @(posedge clk); while (!s_tready);
    w.key  = k;
    w.feat = next_feature(k, p);
    feature_queue.push_back(w);
    words_sent++;
  endtask

  // Stops the input stream and waits until every expected word has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (feature_queue.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_VEL_THR: cfg_vel_thr = value[THR_W-1:0];
      REG_REL_THR: cfg_rel_thr = value[POS_W-1:0];
      REG_HOLDOFF: cfg_holdoff = value[HOLD_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic configure(input logic [THR_W-1:0] thr, input logic signed [POS_W-1:0] rel,
                           input logic [HOLD_W-1:0] hold);
    apb_write(REG_VEL_THR, {{(PDATA_W - THR_W){1'b0}}, thr});
    apb_write(REG_REL_THR, {{(PDATA_W - POS_W){1'b0}}, rel});
    apb_write(REG_HOLDOFF, {{(PDATA_W - HOLD_W){1'b0}}, hold});
  endtask

  task automatic maybe_noise();
    if ($urandom_range(0, 5) == 0)
      send_sample(KEY_W'($urandom_range(0, KEYS - 1)), POS_W'($urandom_range(0, 65535)));
  endtask

  // One press: a velocity ramp that peaks, then samples jittered around a level just above the release level.
  task automatic play_gesture(input logic [KEY_W-1:0] k);
    int a, dir, p, n, target, i;
    int vstep[5];
    a = $urandom_range(8, 20000);
    dir = $urandom_range(0, 1) ? 1 : -1;
    vstep = '{a / 4, a / 2, a, a / 3, a / 8};
    p = int'(prev_pos[k]);
    for (i = 0; i < 5; i++) begin
      p = int'(clamp_pos(p + dir * vstep[i]));
      maybe_noise();
      send_sample(k, POS_W'(p));
    end
    target = int'(cfg_rel_thr) + $urandom_range(1, 3000);
    n = (cfg_holdoff < 40) ? int'(cfg_holdoff) + 2 : $urandom_range(2, 40);
    for (i = 0; i < n; i++) begin
      maybe_noise();
      send_sample(k, clamp_pos(target + $urandom_range(0, 64) - 32));
    end
  endtask

  // Mostly presses on a few busy keys or any key, with runs of random samples between.
  task automatic play_events(input int count);
    int stop;
    logic [KEY_W-1:0] k;
    stop = words_sent + count;
    while (words_sent < stop) begin
      k = $urandom_range(0, 1) ? KEY_W'($urandom_range(0, 3))
                               : KEY_W'($urandom_range(0, KEYS - 1));
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 6))
          send_sample(KEY_W'($urandom_range(0, KEYS - 1)), POS_W'($urandom_range(0, 65535)));
      else
        play_gesture(k);
    end
  endtask

  // Full-scale positions and alternating bit patterns under the reset settings.
  task automatic test_field_extremes();
    send_sample(0, 16'sh7FFF);
    send_sample(0, 16'sh8000);
    send_sample(0, 16'sh7FFF);
    send_sample(0, 16'sh0000);
    // Velocities of +65535 then -65535 give the widest possible range.
    send_sample(63, 16'sh8000);
    send_sample(63, 16'sh7FFF);
    send_sample(63, 16'sh8000);
    send_sample(63, 16'sh0000);
    send_sample(21, 16'sh5555);
    send_sample(42, 16'shAAAA);
    send_sample(42, 16'sh5555);
    send_sample(21, 16'shAAAA);
    drain();
  endtask

  // A range equal to the top threshold must not count as a strike.
  task automatic test_threshold_limits();
    configure(17'd131070, 16'sh0000, 16'd0);
    send_sample(62, 16'sh8000);
    send_sample(62, 16'sh7FFF);
    send_sample(62, 16'sh8000);
    drain();
  endtask

  // Release level at both ends, and holdoffs that the counter can never exceed here.
  task automatic test_release_and_holdoff_limits();
    configure(17'd0, 16'sh7FFF, 16'd0);
    send_sample(10, 16'sd1000);
    send_sample(10, 16'sd5000);
    send_sample(10, 16'sd0);
    send_sample(10, 16'sh7FFF);
    drain();
    configure(17'd0, 16'sh8000, 16'hFFFF);
    send_sample(11, 16'sd0);
    send_sample(11, -16'sd100);
    send_sample(11, 16'sd300);
    send_sample(11, 16'sd0);
    drain();
    configure(17'd0, 16'sh8000, 16'd65534);
    send_sample(12, -16'sd100);
    send_sample(12, 16'sd300);
    send_sample(12, 16'sd0);
    drain();
  endtask

  // Several random settings, each followed by a few hundred samples.
  task automatic test_random_gestures();
    logic [THR_W-1:0]        thr;
    logic signed [POS_W-1:0] rel;
    logic [HOLD_W-1:0]       hold;
    repeat (6) begin
      case ($urandom_range(0, 4))
        0:       thr = '0;
        1:       thr = 17'd131070;
        2:       thr = THR_W'($urandom_range(0, 131071));
        default: thr = THR_W'($urandom_range(0, 4000));
      endcase
      case ($urandom_range(0, 3))
        0:       rel = 16'sh8000;
        1:       rel = 16'sh7FFF;
        default: rel = POS_W'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 7))
        0:       hold = '0;
        1:       hold = 16'd65534;
        2:       hold = 16'hFFFF;
        3:       hold = HOLD_W'($urandom_range(7, 40));
        default: hold = HOLD_W'($urandom_range(1, 6));
      endcase
      configure(thr, rel, hold);
      play_events(200);
      drain();
    end
  endtask

  // Back-to-back words on both sides with short holdoffs.
  task automatic test_steady_stream();
    no_idle = 1'b1;
    configure(THR_W'($urandom_range(0, 3000)), POS_W'($urandom_range(0, 65535)),
              HOLD_W'($urandom_range(0, 3)));
    play_events(300);
    drain();
  endtask

  // Output side: random stall bursts unless idling is switched off.
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      m_tready   <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 9) == 0) begin
      ready_hold <= $urandom_range(0, 13);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare each accepted feature word with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (feature_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", m_tdata));
      end else begin
        head = feature_queue.pop_front();
        words_checked++;
        if (head.feat != '0) active_words++;
        if (m_tdata[KEY_W-1:0] !== head.key)
          report_mismatch($sformatf("key_out %0d, expected %0d",
                                    m_tdata[KEY_W-1:0], head.key));
        if (m_tdata[KEY_W +: FEAT_W] !== head.feat)
          report_mismatch($sformatf("key %0d feature_value %0d, expected %0d",
                                    head.key, m_tdata[KEY_W +: FEAT_W], head.feat));
      end
    end
  end

  initial begin
    foreach (prev_pos[i]) begin
      prev_pos[i]    = '0;
      key_feat[i]    = '0;
      frame_count[i] = '0;
      for (int j = 0; j < STORED; j++) vel_hist[i][j] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_field_extremes();
    test_threshold_limits();
    test_release_and_holdoff_limits();
    test_random_gestures();
    test_steady_stream();
    repeat (8) @(posedge clk);
    $display("Sent %0d position words over %0d register writes; checked %0d feature words,",
             words_sent, reg_writes, words_checked);
    $display("%0d of them carrying an active strike feature; %0d mismatches.",
             active_words, errors);
    if (errors == 0)
      $display("[key_strike_percussiveness_detector_core] OK");
    else
      $display("[key_strike_percussiveness_detector_core] ERROR");
    $finish;
  end

endmodule

FILE: sim.f
design/kspd_pkg.sv
design/kspd_cfg_regs.sv
design/kspd_state_ram.sv
design/kspd_update.sv
design/key_strike_percussiveness_detector_core.sv
tb/tb_key_strike_percussiveness_detector_core.sv
